[src/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// shared widths, word types and arithmetic helpers for the segment pair
// closest point pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int DEN_W     = 2 * DOT_W;
  localparam int NUM_W     = DEN_W + 1;
  localparam int PARAM_W   = FRAC_BITS + 1;
  localparam int TN_W      = DOT_W + PARAM_W + 2;
  localparam int PT_W      = COORD_BITS + FRAC_BITS + 4;
  localparam int DQ_W      = PT_W + 1;
  localparam int SQ_W      = 2 * DQ_W;
  localparam int GAP_SUM_W = SQ_W + 2;
  localparam int DIV_LAT   = FRAC_BITS + 1;

  localparam int POINT_W = 32;
  localparam int GAP_W   = 52;
  localparam int CODE_W  = 3;
  localparam int EPS_W   = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [ADDR_W-3:0] REG_EPS_INDEX = '0;
  localparam logic [PARAM_W-1:0] ONE_Q = PARAM_W'(1) << FRAC_BITS;

  typedef enum logic [CODE_W-1:0] {
    CASE_BOTH_DEGEN   = 3'd0,
    CASE_FIRST_DEGEN  = 3'd1,
    CASE_SECOND_DEGEN = 3'd2,
    CASE_PARALLEL     = 3'd3,
    CASE_GENERAL      = 3'd4
  } case_code_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg0_start_x;
    logic signed [COORD_BITS-1:0] seg0_start_y;
    logic signed [COORD_BITS-1:0] seg0_start_z;
    logic signed [COORD_BITS-1:0] seg0_end_x;
    logic signed [COORD_BITS-1:0] seg0_end_y;
    logic signed [COORD_BITS-1:0] seg0_end_z;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_start_z;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg1_end_z;
  } ssc_in_t;

  typedef struct packed {
    logic [PARAM_W-1:0]        param_first;
    logic [PARAM_W-1:0]        param_second;
    logic signed [POINT_W-1:0] near0_x;
    logic signed [POINT_W-1:0] near0_y;
    logic signed [POINT_W-1:0] near0_z;
    logic signed [POINT_W-1:0] near1_x;
    logic signed [POINT_W-1:0] near1_y;
    logic signed [POINT_W-1:0] near1_z;
    logic [GAP_W-1:0]          gap_squared;
    logic [CODE_W-1:0]         case_code;
  } ssc_out_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] p0;
    logic [2:0][DIFF_W-1:0]     d0;
    logic [2:0][COORD_BITS-1:0] p1;
    logic [2:0][DIFF_W-1:0]     d1;
  } geom_t;

  typedef struct packed {
    geom_t              g;
    logic [DOT_W-1:0]   a;
    logic [DOT_W-1:0]   e;
    logic [DOT_W-1:0]   b;
    logic [DOT_W-1:0]   c;
    logic [DOT_W-1:0]   f;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   num;
    case_code_t         code;
  } setup_t;

  function automatic logic [DIFF_W-1:0] diff_of(input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y);
    return DIFF_W'($signed(x)) - DIFF_W'($signed(y));
  endfunction

  function automatic logic [PROD_W-1:0] mul_diff(input logic [DIFF_W-1:0] x,
                                                 input logic [DIFF_W-1:0] y);
    return PROD_W'($signed(x)) * PROD_W'($signed(y));
  endfunction

  function automatic logic [DOT_W-1:0] sum3(input logic [2:0][PROD_W-1:0] v);
    return DOT_W'($signed(v[0])) + DOT_W'($signed(v[1])) + DOT_W'($signed(v[2]));
  endfunction

  function automatic logic [DEN_W-1:0] mul_dot(input logic [DOT_W-1:0] x,
                                               input logic [DOT_W-1:0] y);
    return DEN_W'($signed(x)) * DEN_W'($signed(y));
  endfunction

endpackage

`default_nettype wire

[src/segment_segment_closest_points_unit.sv]
// ----------------------------------------------------------------------------
// segment_segment_closest_points_unit
// closest points, parameters and squared gap of two 3d segments
// ----------------------------------------------------------------------------
// usage
//   pair channel: pair_valid/pair_stall/pair_word carry one segment pair word
//   result channel: result_valid/result_stall/result_word carry one result word
//   a word moves at a clock edge with valid high and stall low
//   one result word per pair word, in order
//   path from acceptance to result_valid: the setup stages, the 17 stage divider
//   pipelines (three side by side for s, then one for t) and the point stages
//   throughput: one pair word per cycle while no result word waits under result_stall
//   a stalled result word freezes the whole pipeline; pair_stall is high
//   exactly while a result word waits under result_stall
//   reset clears all valid bits and sets degenerate_epsilon to 0
//   degenerate_epsilon sits at byte address 0 of the apb port and must be
//   written by the user, unchecked by the block, only while the pipeline is empty
// ----------------------------------------------------------------------------
`default_nettype none

module segment_segment_closest_points_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pair_valid,
  output logic                       pair_stall,
  input  ssc_pkg::ssc_in_t           pair_word,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ssc_pkg::ssc_out_t          result_word,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssc_pkg::ADDR_W-1:0] paddr,
  input  logic [ssc_pkg::DATA_W-1:0] pwdata,
  output logic [ssc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ssc_pkg::*;

  typedef struct packed {
    logic             valid;
    geom_t            g;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] e;
    logic [DOT_W-1:0] f;
    case_code_t       code;
  } ctx_a_t;

  typedef struct packed {
    logic               valid;
    geom_t              g;
    logic [DOT_W-1:0]   e;
    case_code_t         code;
    logic [PARAM_W-1:0] s0;
    logic [PARAM_W-1:0] s_low;
    logic [PARAM_W-1:0] s_high;
  } ctx_b_t;

  typedef struct packed {
    logic               valid;
    geom_t              g;
    case_code_t         code;
    logic [PARAM_W-1:0] s0;
    logic [PARAM_W-1:0] s_low;
    logic [PARAM_W-1:0] s_high;
    logic               t_neg;
    logic               t_over;
  } ctx_c_t;

  logic en;
  logic [EPS_W-1:0] eps;
  logic reg_hit;

  logic su_valid;
  setup_t su;
  logic [PARAM_W-1:0] s_gen, s_low, s_high, t_quo;
  ctx_a_t ctx_a_in;
  ctx_a_t line_a [DIV_LAT];
  ctx_a_t xa;
  ctx_b_t ctx_b_in, ctx_b1, ctx_b2;
  logic [TN_W-1:0] bs, fsh, tn, tn_hi, e_sh;
  logic [PARAM_W-1:0] s0_c;
  ctx_c_t ctx_c_in;
  ctx_c_t line_c [DIV_LAT];
  ctx_c_t xc;
  logic [PARAM_W-1:0] s_fin, t_fin;

  assign en = !(result_valid && result_stall);
  assign pair_stall = !en;

  assign reg_hit = paddr[ADDR_W-1:2] == REG_EPS_INDEX;
  assign pready = 1'b1;
  assign prdata = reg_hit ? DATA_W'(eps) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      eps <= pwdata[EPS_W-1:0];
    end
  end

  ssc_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pair_valid),
    .in_word   (pair_word),
    .eps       (eps),
    .out_valid (su_valid),
    .out_word  (su)
  );

  ssc_div u_div_gen (
    .clk    (clk),
    .en     (en),
    .num_hi (su.num),
    .num_lo ('0),
    .den    (su.den),
    .quo    (s_gen)
  );

  ssc_div u_div_low (
    .clk    (clk),
    .en     (en),
    .num_hi (-NUM_W'($signed(su.c))),
    .num_lo ('0),
    .den    (DEN_W'(su.a)),
    .quo    (s_low)
  );

  ssc_div u_div_high (
    .clk    (clk),
    .en     (en),
    .num_hi (NUM_W'($signed(su.b)) - NUM_W'($signed(su.c))),
    .num_lo ('0),
    .den    (DEN_W'(su.a)),
    .quo    (s_high)
  );

  always_comb begin
    ctx_a_in.valid = su_valid;
    ctx_a_in.g = su.g;
    ctx_a_in.b = su.b;
    ctx_a_in.e = su.e;
    ctx_a_in.f = su.f;
    ctx_a_in.code = su.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        line_a[k].valid <= 1'b0;
      end
    end else if (en) begin
      line_a[0] <= ctx_a_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        line_a[k] <= line_a[k-1];
      end
    end
  end

  assign xa = line_a[DIV_LAT-1];

  // s from the line solution only in the general case, else 0
  always_comb begin
    s0_c = (xa.code == CASE_GENERAL) ? s_gen : '0;
    ctx_b_in.valid = xa.valid;
    ctx_b_in.g = xa.g;
    ctx_b_in.e = xa.e;
    ctx_b_in.code = xa.code;
    ctx_b_in.s0 = s0_c;
    ctx_b_in.s_low = s_low;
    ctx_b_in.s_high = s_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_b1.valid <= 1'b0;
      ctx_b2.valid <= 1'b0;
    end else if (en) begin
      ctx_b1 <= ctx_b_in;
      ctx_b2 <= ctx_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bs <= TN_W'($signed(xa.b)) * TN_W'($signed({1'b0, s0_c}));
      fsh <= TN_W'($signed(xa.f)) <<< FRAC_BITS;
      tn <= bs + fsh;
    end
  end

  assign tn_hi = $signed(tn) >>> FRAC_BITS;
  assign e_sh = TN_W'($signed(ctx_b2.e)) <<< FRAC_BITS;

  ssc_div u_div_t (
    .clk    (clk),
    .en     (en),
    .num_hi (NUM_W'($signed(tn_hi))),
    .num_lo (tn[FRAC_BITS-1:0]),
    .den    (DEN_W'(ctx_b2.e)),
    .quo    (t_quo)
  );

  always_comb begin
    ctx_c_in.valid = ctx_b2.valid;
    ctx_c_in.g = ctx_b2.g;
    ctx_c_in.code = ctx_b2.code;
    ctx_c_in.s0 = ctx_b2.s0;
    ctx_c_in.s_low = ctx_b2.s_low;
    ctx_c_in.s_high = ctx_b2.s_high;
    ctx_c_in.t_neg = tn[TN_W-1];
    ctx_c_in.t_over = $signed(tn) > $signed(e_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        line_c[k].valid <= 1'b0;
      end
    end else if (en) begin
      line_c[0] <= ctx_c_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        line_c[k] <= line_c[k-1];
      end
    end
  end

  assign xc = line_c[DIV_LAT-1];

  // degenerate cases zero s, t or both (s = -c/a if only t); else a clamped t re-solves s
  always_comb begin
    case (xc.code)
      CASE_BOTH_DEGEN: begin
        s_fin = '0;
        t_fin = '0;
      end
      CASE_FIRST_DEGEN: begin
        s_fin = '0;
        t_fin = t_quo;
      end
      CASE_SECOND_DEGEN: begin
        s_fin = xc.s_low;
        t_fin = '0;
      end
      default: begin
        t_fin = t_quo;
        if (xc.t_neg) begin
          s_fin = xc.s_low;
        end else if (xc.t_over) begin
          s_fin = xc.s_high;
        end else begin
          s_fin = xc.s0;
        end
      end
    endcase
  end

  ssc_points u_points (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (xc.valid),
    .in_geom   (xc.g),
    .in_s      (s_fin),
    .in_t      (t_fin),
    .in_code   (xc.code),
    .out_valid (result_valid),
    .out_word  (result_word)
  );

`ifndef NO_ASSERTIONS
  a_params_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.param_first <= ONE_Q && result_word.param_second <= ONE_Q))
    else $error("parameter above one");

  a_both_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.case_code == CASE_BOTH_DEGEN) |->
      (result_word.param_first == '0 && result_word.param_second == '0))
    else $error("degenerate pair with nonzero parameter");

  a_second_degen_t: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.case_code == CASE_SECOND_DEGEN) |->
      result_word.param_second == '0)
    else $error("second degenerate with nonzero t");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(t_quo))
    else $error("divider moved under stall");
`endif

endmodule

`default_nettype wire

[src/ssc_div.sv]
// ----------------------------------------------------------------------------
// ssc_div
// pipelined clamped divider: one restoring step per stage, quotient in
// [0,1] with FRAC_BITS fraction bits
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ssc_pkg::NUM_W-1:0]     num_hi,
  input  logic [ssc_pkg::FRAC_BITS-1:0] num_lo,
  input  logic [ssc_pkg::DEN_W-1:0]     den,
  output logic [ssc_pkg::PARAM_W-1:0]   quo
);
  import ssc_pkg::*;

  typedef struct packed {
    logic                 zero;
    logic                 one;
    logic [DEN_W-1:0]     rem;
    logic [FRAC_BITS-1:0] lo;
    logic [FRAC_BITS-1:0] q;
    logic [DEN_W-1:0]     den;
  } div_stage_t;

  div_stage_t st [FRAC_BITS+1];

  function automatic div_stage_t div_step(input div_stage_t x);
    div_stage_t y;
    logic [DEN_W:0] trial;
    y = x;
    trial = {x.rem, x.lo[FRAC_BITS-1]};
    if (trial >= {1'b0, x.den}) begin
      y.rem = DEN_W'(trial - {1'b0, x.den});
      y.q = {x.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      y.rem = trial[DEN_W-1:0];
      y.q = {x.q[FRAC_BITS-2:0], 1'b0};
    end
    y.lo = {x.lo[FRAC_BITS-2:0], 1'b0};
    return y;
  endfunction

  logic neg;
  assign neg = num_hi[NUM_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].zero <= neg || (num_hi == '0 && num_lo == '0);
      st[0].one  <= !neg && (num_hi >= {1'b0, den});
      st[0].rem  <= num_hi[DEN_W-1:0];
      st[0].lo   <= num_lo;
      st[0].q    <= '0;
      st[0].den  <= den;
      for (int i = 0; i < FRAC_BITS; i++) begin
        st[i+1] <= div_step(st[i]);
      end
    end
  end

  assign quo = st[FRAC_BITS].zero ? '0 :
               st[FRAC_BITS].one  ? ONE_Q : {1'b0, st[FRAC_BITS].q};

endmodule

`default_nettype wire

[src/ssc_setup.sv]
// ----------------------------------------------------------------------------
// ssc_setup
// five stage front end: differences, dot products, determinant and
// numerator of the line solution, case classification
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_setup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  ssc_pkg::ssc_in_t          in_word,
  input  logic [ssc_pkg::EPS_W-1:0] eps,
  output logic                      out_valid,
  output ssc_pkg::setup_t           out_word
);
  import ssc_pkg::*;

  logic [2:0][COORD_BITS-1:0] sp0, sq0, sp1, sq1;
  geom_t g_in, g1, g2, g3, g4;
  logic [2:0][DIFF_W-1:0] r_in, r1;
  logic [2:0][PROD_W-1:0] pa, pe, pb, pc, pf;
  logic [DOT_W-1:0] a3, e3, b3, c3, f3;
  logic [DOT_W-1:0] a4, e4, b4, c4, f4;
  logic [DEN_W-1:0] ae, bb, bf, ce;
  logic a_deg, e_deg;
  logic v1, v2, v3, v4;
  logic [DEN_W-1:0] den_c;
  logic [NUM_W-1:0] num_c;
  case_code_t code_c;

  always_comb begin
    sp0 = {in_word.seg0_start_z, in_word.seg0_start_y, in_word.seg0_start_x};
    sq0 = {in_word.seg0_end_z, in_word.seg0_end_y, in_word.seg0_end_x};
    sp1 = {in_word.seg1_start_z, in_word.seg1_start_y, in_word.seg1_start_x};
    sq1 = {in_word.seg1_end_z, in_word.seg1_end_y, in_word.seg1_end_x};
    g_in.p0 = sp0;
    g_in.p1 = sp1;
    for (int i = 0; i < 3; i++) begin
      g_in.d0[i] = diff_of(sq0[i], sp0[i]);
      g_in.d1[i] = diff_of(sq1[i], sp1[i]);
      r_in[i] = diff_of(sp0[i], sp1[i]);
    end
  end

  always_comb begin
    den_c = ae - bb;
    num_c = NUM_W'($signed(bf)) - NUM_W'($signed(ce));
    if (a_deg && e_deg) begin
      code_c = CASE_BOTH_DEGEN;
    end else if (a_deg) begin
      code_c = CASE_FIRST_DEGEN;
    end else if (e_deg) begin
      code_c = CASE_SECOND_DEGEN;
    end else if (den_c > DEN_W'(eps)) begin
      code_c = CASE_GENERAL;
    end else begin
      code_c = CASE_PARALLEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= g_in;
      r1 <= r_in;
      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        pa[i] <= mul_diff(g1.d0[i], g1.d0[i]);
        pe[i] <= mul_diff(g1.d1[i], g1.d1[i]);
        pb[i] <= mul_diff(g1.d0[i], g1.d1[i]);
        pc[i] <= mul_diff(g1.d0[i], r1[i]);
        pf[i] <= mul_diff(g1.d1[i], r1[i]);
      end
      g3 <= g2;
      a3 <= sum3(pa);
      e3 <= sum3(pe);
      b3 <= sum3(pb);
      c3 <= sum3(pc);
      f3 <= sum3(pf);
      g4 <= g3;
      a4 <= a3;
      e4 <= e3;
      b4 <= b3;
      c4 <= c3;
      f4 <= f3;
      ae <= mul_dot(a3, e3);
      bb <= mul_dot(b3, b3);
      bf <= mul_dot(b3, f3);
      ce <= mul_dot(c3, e3);
      a_deg <= a3 <= DOT_W'(eps);
      e_deg <= e3 <= DOT_W'(eps);
      out_word.g <= g4;
      out_word.a <= a4;
      out_word.e <= e4;
      out_word.b <= b4;
      out_word.c <= c4;
      out_word.f <= f4;
      out_word.den <= den_c;
      out_word.num <= num_c;
      out_word.code <= code_c;
    end
  end

endmodule

`default_nettype wire

[src/ssc_points.sv]
// ----------------------------------------------------------------------------
// ssc_points
// five stage back end: closest points from the parameters, squared gap,
// result word register
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_points (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  ssc_pkg::geom_t              in_geom,
  input  logic [ssc_pkg::PARAM_W-1:0] in_s,
  input  logic [ssc_pkg::PARAM_W-1:0] in_t,
  input  ssc_pkg::case_code_t         in_code,
  output logic                        out_valid,
  output ssc_pkg::ssc_out_t           out_word
);
  import ssc_pkg::*;

  logic v1, v2, v3, v4;
  geom_t g1;
  logic [PARAM_W-1:0] s1, s2, s3, s4, t1, t2, t3, t4;
  case_code_t code1, code2, code3, code4;
  logic [2:0][PT_W-1:0] ds0, ds1, ps0, ps1, n0, n1, n0_4, n1_4;
  logic [2:0][SQ_W-1:0] sq;
  logic [2:0][DQ_W-1:0] dq_c;
  logic [GAP_SUM_W-1:0] gap_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq_c[i] = DQ_W'($signed(n0[i])) - DQ_W'($signed(n1[i]));
    end
    gap_sum = GAP_SUM_W'(sq[0]) + GAP_SUM_W'(sq[1]) + GAP_SUM_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= in_geom;
      s1 <= in_s;
      t1 <= in_t;
      code1 <= in_code;
      s2 <= s1;
      t2 <= t1;
      code2 <= code1;
      for (int i = 0; i < 3; i++) begin
        ds0[i] <= PT_W'($signed(g1.d0[i])) * PT_W'($signed({1'b0, s1}));
        ds1[i] <= PT_W'($signed(g1.d1[i])) * PT_W'($signed({1'b0, t1}));
        ps0[i] <= PT_W'($signed(g1.p0[i])) <<< FRAC_BITS;
        ps1[i] <= PT_W'($signed(g1.p1[i])) <<< FRAC_BITS;
        n0[i] <= ps0[i] + ds0[i];
        n1[i] <= ps1[i] + ds1[i];
        sq[i] <= SQ_W'($signed(dq_c[i])) * SQ_W'($signed(dq_c[i]));
      end
      s3 <= s2;
      t3 <= t2;
      code3 <= code2;
      s4 <= s3;
      t4 <= t3;
      code4 <= code3;
      n0_4 <= n0;
      n1_4 <= n1;
      out_word.param_first <= s4;
      out_word.param_second <= t4;
      out_word.near0_x <= n0_4[0][POINT_W-1:0];
      out_word.near0_y <= n0_4[1][POINT_W-1:0];
      out_word.near0_z <= n0_4[2][POINT_W-1:0];
      out_word.near1_x <= n1_4[0][POINT_W-1:0];
      out_word.near1_y <= n1_4[1][POINT_W-1:0];
      out_word.near1_z <= n1_4[2][POINT_W-1:0];
      out_word.gap_squared <= gap_sum[FRAC_BITS +: GAP_W];
      out_word.case_code <= code4;
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// closest points between two 3d segments: directed corner pairs, then random
// pairs under several idle and stall phases, with epsilon changed between
// phases over the apb port; every result word is checked field by field
// against a predictor that computes each pair exactly
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ONE = 64'd1 << FRAC_BITS;

  class closest_point_board;
    ssc_out_t pending[$];
    longint epsilon;
    int mismatches;
    int checked;

    function new();
      epsilon = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // clamp(num/den) to [0,1] in q1.16
    function longint clamp_quot(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] q;
      if (num <= 0) return 0;
      if (num >= den) return ONE;
      q = (num <<< FRAC_BITS) / den;
      return longint'(q);
    endfunction

    function ssc_out_t closest_points(ssc_in_t w);
      longint p0[3], p1[3], d0[3], d1[3], r[3];
      longint a, e, b, c, f, s, t, n0, n1, dq;
      logic signed [127:0] den, tn, gap;
      case_code_t code;
      ssc_out_t o;
      p0[0] = w.seg0_start_x; p0[1] = w.seg0_start_y; p0[2] = w.seg0_start_z;
      d0[0] = longint'(w.seg0_end_x) - p0[0];
      d0[1] = longint'(w.seg0_end_y) - p0[1];
      d0[2] = longint'(w.seg0_end_z) - p0[2];
      p1[0] = w.seg1_start_x; p1[1] = w.seg1_start_y; p1[2] = w.seg1_start_z;
      d1[0] = longint'(w.seg1_end_x) - p1[0];
      d1[1] = longint'(w.seg1_end_y) - p1[1];
      d1[2] = longint'(w.seg1_end_z) - p1[2];
      for (int i = 0; i < 3; i++) r[i] = p0[i] - p1[i];
      a = 0; e = 0; b = 0; c = 0; f = 0;
      for (int i = 0; i < 3; i++) begin
        a += d0[i] * d0[i]; e += d1[i] * d1[i]; b += d0[i] * d1[i];
        c += d0[i] * r[i]; f += d1[i] * r[i];
      end
      if (a <= epsilon && e <= epsilon) begin
        code = CASE_BOTH_DEGEN; s = 0; t = 0;
      end else if (a <= epsilon) begin
        code = CASE_FIRST_DEGEN; s = 0; t = clamp_quot(f, e);
      end else if (e <= epsilon) begin
        code = CASE_SECOND_DEGEN; t = 0; s = clamp_quot(-c, a);
      end else begin
        den = 128'(a) * 128'(e) - 128'(b) * 128'(b);
        if (den > epsilon) begin
          code = CASE_GENERAL;
          s = clamp_quot(128'(b) * 128'(f) - 128'(c) * 128'(e), den);
        end else begin
          code = CASE_PARALLEL; s = 0;
        end
        tn = 128'(b) * 128'(s) + 128'(f) * 128'(ONE);
        if (tn < 0) begin
          t = 0; s = clamp_quot(-c, a);
        end else if (tn > 128'(e) * 128'(ONE)) begin
          t = ONE; s = clamp_quot(b - c, a);
        end else begin
          t = longint'(tn / e);
        end
      end
      o.param_first = s[PARAM_W-1:0];
      o.param_second = t[PARAM_W-1:0];
      gap = 0;
      for (int i = 0; i < 3; i++) begin
        n0 = p0[i] * ONE + d0[i] * s;
        n1 = p1[i] * ONE + d1[i] * t;
        dq = n0 - n1;
        gap += 128'(dq) * 128'(dq);
        case (i)
          0: begin o.near0_x = n0[31:0]; o.near1_x = n1[31:0]; end
          1: begin o.near0_y = n0[31:0]; o.near1_y = n1[31:0]; end
          default: begin o.near0_z = n0[31:0]; o.near1_z = n1[31:0]; end
        endcase
      end
      o.gap_squared = gap[GAP_W+FRAC_BITS-1:FRAC_BITS];
      o.case_code = code;
      return o;
    endfunction

    function void note_pair(ssc_in_t w);
      pending.push_back(closest_points(w));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(ssc_out_t got);
      ssc_out_t want;
      if (pending.size() == 0) begin
        report("result word with none expected", 1, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.param_first !== want.param_first)
        report("param_first", got.param_first, want.param_first);
      if (got.param_second !== want.param_second)
        report("param_second", got.param_second, want.param_second);
      if (got.near0_x !== want.near0_x) report("near0_x", got.near0_x, want.near0_x);
      if (got.near0_y !== want.near0_y) report("near0_y", got.near0_y, want.near0_y);
      if (got.near0_z !== want.near0_z) report("near0_z", got.near0_z, want.near0_z);
      if (got.near1_x !== want.near1_x) report("near1_x", got.near1_x, want.near1_x);
      if (got.near1_y !== want.near1_y) report("near1_y", got.near1_y, want.near1_y);
      if (got.near1_z !== want.near1_z) report("near1_z", got.near1_z, want.near1_z);
      if (got.gap_squared !== want.gap_squared)
        report("gap_squared", got.gap_squared, want.gap_squared);
      if (got.case_code !== want.case_code)
        report("case_code", got.case_code, want.case_code);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  ssc_in_t pair_word = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ssc_out_t result_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  closest_point_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int pairs_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  segment_segment_closest_points_unit DUT (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair_word(pair_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_word(result_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_result(result_word);
      if ((result_valid && !result_stall) || (pair_valid && !pair_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task send_pair(ssc_in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      pair_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    pair_word <= w;
    pair_valid <= 1'b1;
    @(posedge clk);
    while (pair_stall) @(posedge clk);
    board.note_pair(w);
    pairs_sent++;
  endtask

  task write_epsilon(logic [EPS_W-1:0] value);
    paddr <= {REG_EPS_INDEX, 2'b00};
    pwdata <= DATA_W'(value);
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.epsilon = value;
  endtask

  task drain;
    pair_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic ssc_in_t random_pair(int mode);
    ssc_in_t w;
    logic [COORD_BITS-1:0] v[12];
    int span;
    span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(10, 2));
    for (int i = 0; i < 12; i++) begin
      if (mode == 0) v[i] = COORD_BITS'($urandom);
      else v[i] = COORD_BITS'($signed($urandom_range(2 * span)) - span);
    end
    case (mode)
      // short or degenerate first or second segment
      2: for (int i = 0; i < 3; i++) v[3 + i] = v[i] + COORD_BITS'($urandom_range(2));
      3: for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i] + COORD_BITS'($urandom_range(2));
      // parallel: second direction a multiple of the first
      4: for (int i = 0; i < 3; i++) begin
        v[3 + i] = v[i] + COORD_BITS'($signed($urandom_range(40)) - 20);
        v[9 + i] = v[6 + i] + (v[3 + i] - v[i]) * COORD_BITS'($signed($urandom_range(4)) - 2);
      end
      default: ;
    endcase
    w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return w;
  endfunction

  task directed_pairs;
    ssc_in_t w;
    logic [COORD_BITS-1:0] mx, mn;
    mx = 16'h7fff;
    mn = 16'h8000;
    send_pair('0);
    send_pair('1);
    send_pair({mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn});
    send_pair({mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx});
    send_pair({mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx});
    send_pair({mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx});
    send_pair({mn, mx, mn, mn, mx, mn, mx, mn, mx, mn, mx, mn});
    send_pair({mx, 16'h0, 16'h0, mx, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
    // crossing lines, interior solution
    send_pair({-16'sd10, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               16'sd0, -16'sd10, 16'sd5, 16'sd0, 16'sd10, 16'sd5});
    // parallel overlapping, and parallel disjoint on both sides
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               16'sd3, 16'sd2, 16'sd0, 16'sd7, 16'sd2, 16'sd0});
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               16'sd20, 16'sd1, 16'sd0, 16'sd30, 16'sd1, 16'sd0});
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               -16'sd30, 16'sd1, 16'sd0, -16'sd20, 16'sd1, 16'sd0});
    // t clamps low and high
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               16'sd5, 16'sd3, 16'sd0, 16'sd5, 16'sd9, 16'sd0});
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
               16'sd5, -16'sd9, 16'sd0, 16'sd5, -16'sd3, 16'sd0});
    for (int m = 2; m <= 4; m++) begin
      w = random_pair(m);
      send_pair(w);
    end
    // short segments for epsilon tests
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
               16'sd4, 16'sd4, 16'sd4, 16'sd4, 16'sd5, 16'sd4});
    send_pair({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0,
               16'sd9, 16'sd1, 16'sd2, 16'sd9, 16'sd1, 16'sd2});
  endtask

  task random_phase(int count);
    for (int i = 0; i < count; i++)
      send_pair(random_pair($urandom_range(6) > 4 ? 1 : $urandom_range(4)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_pairs();
    drain();
    write_epsilon(16'd2);
    directed_pairs();
    drain();
    write_epsilon(16'hffff);
    directed_pairs();
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 49 : 21) : 0;
      recv_stall_pct = (phase == 2) ? 49 : (phase == 3 ? 21 : 0);
      write_epsilon(phase == 0 ? 16'd0 : 16'($urandom_range(phase == 2 ? 65535 : 40)));
      random_phase(100);
      drain();
    end
    write_epsilon(16'd0);
    recv_stall_pct = 0;
    drain();
    $display("covered %0d segment pairs, %0d results checked, epsilon swept 0..65535",
             pairs_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

`default_nettype wire

[files.f]
src/ssc_pkg.sv
src/ssc_div.sv
src/ssc_setup.sv
src/ssc_points.sv
src/segment_segment_closest_points_unit.sv
tb/tb_top.sv
